/* rtl/crc8fc_pkg.sv */
`timescale 1ns / 1ps
// Package for the CRC-8 frame checker: frame geometry, register indexes,
// status codes, shared structs and the byte-wide CRC-8 update. No dependencies.

package crc8fc_pkg;

  // frame geometry
  localparam int FRAME_LEN = 32;
  localparam int POS_W     = $clog2(FRAME_LEN);
  localparam logic [POS_W-1:0] POS_FIRST  = '0;
  localparam logic [POS_W-1:0] POS_LENGTH = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_LEN - 1);

  // crc-8 constants
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h07;

  // configuration port
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT = CFG_IDX_W'(1);
  localparam logic [7:0] START_MARKER_RST  = 8'd0;
  localparam logic [7:0] PAYLOAD_LIMIT_RST = 8'd26;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_MARKER = 2'd1;
  localparam logic [1:0] ST_BAD_LENGTH = 2'd2;
  localparam logic [1:0] ST_BAD_CRC    = 2'd3;

  // configuration values handed to the engine
  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] payload_limit;
  } cfg_t;

  // engine status seen by the top level checks
  typedef struct packed {
    logic             in_full;
    logic             advance;
    logic             last;
    logic [POS_W-1:0] pos;
  } eng_stat_t;

  // one byte of crc-8, msb first, unrolled over the eight bits
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/crc8fc_intf.sv */
`timescale 1ns / 1ps
// Channel interfaces of the CRC-8 frame checker: byte input, status output
// and configuration write. Depends on crc8fc_pkg.

interface crc8fc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface crc8fc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] computed_crc;

  modport source (output valid, output status, output computed_crc, input ready);
  modport sink   (input valid, input status, input computed_crc, output ready);
endinterface

interface crc8fc_cfg_if import crc8fc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/crc8fc_cfg_regs.sv */
`timescale 1ns / 1ps
// Configuration registers of the CRC-8 frame checker (start marker, payload limit).
// Depends on crc8fc_pkg and crc8fc_cfg_if.

module crc8fc_cfg_regs
  import crc8fc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  crc8fc_cfg_if.sink   cfg,
  output cfg_t         cfg_val
);

  logic [7:0] start_marker_r, start_marker_nxt;
  logic [7:0] payload_limit_r, payload_limit_nxt;

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register decode, unknown indexes are dropped
  always_comb begin
    start_marker_nxt  = start_marker_r;
    payload_limit_nxt = payload_limit_r;
    if (cfg.valid) begin
      unique case (cfg.index)
        CFG_START_MARKER:  start_marker_nxt  = cfg.data;
        CFG_PAYLOAD_LIMIT: payload_limit_nxt = cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r  <= START_MARKER_RST;
      payload_limit_r <= PAYLOAD_LIMIT_RST;
    end else begin
      start_marker_r  <= start_marker_nxt;
      payload_limit_r <= payload_limit_nxt;
    end
  end

  assign cfg_val.start_marker  = start_marker_r;
  assign cfg_val.payload_limit = payload_limit_r;

endmodule

/* rtl/crc8fc_engine.sv */
`timescale 1ns / 1ps
// Byte engine of the CRC-8 frame checker: input register, frame position,
// running crc, check flags and the status result register.
// Depends on crc8fc_pkg, crc8fc_in_if and crc8fc_out_if.

module crc8fc_engine
  import crc8fc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  crc8fc_in_if.sink     in_ch,
  crc8fc_out_if.source  out_ch,
  input  cfg_t          cfg_val,
  output eng_stat_t     stat
);

  logic             in_valid_r, in_valid_nxt;
  logic [7:0]       in_byte_r, in_byte_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic             marker_bad_r, marker_bad_nxt;
  logic             length_bad_r, length_bad_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [7:0]       out_crc_r, out_crc_nxt;

  logic       is_last;
  logic       advance;
  logic       in_take;
  logic [1:0] status;

  // the last byte needs room in the result register, others always move on
  assign is_last = (pos_r == POS_LAST);
  assign advance = in_valid_r && (!is_last || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take = in_ch.valid && in_ch.ready;

  // input register
  always_comb begin
    in_valid_nxt = in_valid_r;
    in_byte_nxt  = in_byte_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
      in_byte_nxt  = in_ch.data_byte;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  // first failing check decides the status
  always_comb begin
    if (marker_bad_r) begin
      status = ST_BAD_MARKER;
    end else if (length_bad_r) begin
      status = ST_BAD_LENGTH;
    end else if (crc_r != in_byte_r) begin
      status = ST_BAD_CRC;
    end else begin
      status = ST_OK;
    end
  end

  // frame state update
  always_comb begin
    pos_nxt        = pos_r;
    crc_nxt        = crc_r;
    marker_bad_nxt = marker_bad_r;
    length_bad_nxt = length_bad_r;
    if (advance) begin
      if (is_last) begin
        pos_nxt        = POS_FIRST;
        crc_nxt        = CRC_INIT;
        marker_bad_nxt = 1'b0;
        length_bad_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        crc_nxt = crc8_update(crc_r, in_byte_r);
        if (pos_r == POS_FIRST) begin
          marker_bad_nxt = (in_byte_r != cfg_val.start_marker);
        end
        if (pos_r == POS_LENGTH) begin
          length_bad_nxt = (in_byte_r > cfg_val.payload_limit);
        end
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_crc_nxt    = out_crc_r;
    if (advance && is_last) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status;
      out_crc_nxt    = crc_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      pos_r        <= POS_FIRST;
      crc_r        <= CRC_INIT;
      marker_bad_r <= 1'b0;
      length_bad_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      in_valid_r   <= in_valid_nxt;
      pos_r        <= pos_nxt;
      crc_r        <= crc_nxt;
      marker_bad_r <= marker_bad_nxt;
      length_bad_r <= length_bad_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    in_byte_r    <= in_byte_nxt;
    out_status_r <= out_status_nxt;
    out_crc_r    <= out_crc_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.computed_crc = out_crc_r;

  assign stat.in_full = in_valid_r;
  assign stat.advance = advance;
  assign stat.last    = is_last;
  assign stat.pos     = pos_r;

endmodule

/* rtl/crc8_frame_checker_core.sv */
`timescale 1ns / 1ps
// CRC-8 frame checker, top level. Takes one byte per cycle, back to back, with the
// unrolled crc-8 update, except while a last byte waits for an untaken status. A
// frame's last byte is held in the input register, its status in the result register.
// Reset (rst_n low, synchronous) restarts frame counting at byte 0, sets the crc
// to 0xFF and loads start_marker = 0, payload_limit = 26.
// Depends on crc8fc_pkg, the channel interfaces, crc8fc_cfg_regs and crc8fc_engine.

module crc8_frame_checker_core
  import crc8fc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  crc8fc_in_if.sink     in_ch,
  crc8fc_out_if.source  out_ch,
  crc8fc_cfg_if.sink    cfg_ch
);

  cfg_t      cfg_val;
  eng_stat_t stat;

  // configuration registers
  crc8fc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_ch),
    .cfg_val (cfg_val)
  );

  // byte engine
  crc8fc_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_val (cfg_val),
    .stat    (stat)
  );

  // a last byte moving on always leaves a result behind
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    stat.advance && stat.last |=> out_ch.valid)
    else $error("last byte of a frame produced no result");

  // a finished frame restarts at byte 0
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    stat.advance && stat.last |=> stat.pos == POS_FIRST)
    else $error("frame position did not restart after the last byte");

  // input stalls only with a byte held in the input register
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> stat.in_full && stat.last && out_ch.valid && !out_ch.ready)
    else $error("input stalled without a blocked last byte");

  // position moves by one per byte otherwise
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    stat.advance && !stat.last |=> stat.pos == $past(stat.pos) + POS_W'(1))
    else $error("frame position skipped");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Testbench for crc8_frame_checker_core: streams fixed-length frames with good and broken
// start markers, payload lengths and crc bytes, predicts every frame status and checks it.
// Depends on crc8fc_pkg, the channel interfaces in crc8fc_intf.sv and the checker rtl.

module tb;
  import crc8fc_pkg::*;

  localparam int CLK_HALF_NS  = 2;
  localparam int RESET_CYCLES = 5;
  localparam int LEN_POS      = 4;
  localparam int BYTE_TARGET  = 1950;
  localparam int IDLE_PCT     = 22;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 6;
  localparam int TIMEOUT_NS   = 1_200_000;

  localparam logic [7:0] MARKER_AT_RESET = 8'h00;
  localparam logic [7:0] LIMIT_AT_RESET  = 8'd26;
  localparam logic [7:0] CRC8_SEED       = 8'hFF;
  localparam logic [7:0] CRC8_POLY       = 8'h07;

  typedef struct {
    logic [1:0] status;
    logic [7:0] crc;
  } frame_result_t;

  typedef enum {LEN_FIT, LEN_EDGE, LEN_OVER} len_kind_t;
  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_t;

  // crc-8 fed one message bit at a time, msb first
  function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0} ^ (fb ? CRC8_POLY : 8'h00);
    end
    return c;
  endfunction

  // frame status predictor and queue of statuses still due
  class frame_scoreboard;
    logic [7:0]    start_marker;
    logic [7:0]    payload_limit;
    int unsigned   byte_pos;
    logic [7:0]    crc_acc;
    bit            marker_bad;
    bit            length_bad;
    frame_result_t due_status[$];
    int            errors;

    function new();
      start_marker  = MARKER_AT_RESET;
      payload_limit = LIMIT_AT_RESET;
      errors        = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      byte_pos   = 0;
      crc_acc    = CRC8_SEED;
      marker_bad = 1'b0;
      length_bad = 1'b0;
    endfunction

    // unknown indexes leave both registers alone
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_START_MARKER:  start_marker = val;
        CFG_PAYLOAD_LIMIT: payload_limit = val;
        default: ;
      endcase
    endfunction

    // one accepted byte; the last byte of a frame yields a status
    function void take_byte(logic [7:0] b);
      frame_result_t r;
      if (byte_pos == FRAME_LEN - 1) begin
        if (marker_bad) r.status = ST_BAD_MARKER;
        else if (length_bad) r.status = ST_BAD_LENGTH;
        else if (crc_acc != b) r.status = ST_BAD_CRC;
        else r.status = ST_OK;
        r.crc = crc_acc;
        due_status.push_back(r);
        restart_frame();
      end else begin
        if (byte_pos == 0) marker_bad = (b != start_marker);
        if (byte_pos == LEN_POS) length_bad = (b > payload_limit);
        crc_acc  = crc8_next(crc_acc, b);
        byte_pos = byte_pos + 1;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_status(logic [1:0] st, logic [7:0] crc);
      frame_result_t r;
      if (due_status.size() == 0) begin
        report($sformatf("status %0d crc %02h with no frame due", st, crc));
      end else begin
        r = due_status.pop_front();
        if (st !== r.status) report($sformatf("status %0d, want %0d", st, r.status));
        if (crc !== r.crc) report($sformatf("computed_crc %02h, want %02h", crc, r.crc));
      end
    endtask

    function int pending();
      return due_status.size();
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  crc8fc_in_if  in_ch();
  crc8fc_out_if out_ch();
  crc8fc_cfg_if cfg_ch();

  crc8_frame_checker_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  frame_scoreboard sb;
  logic [7:0]      frame_bytes[$];
  bit              calm;
  bit              hold_request;
  int              sent;

  // clock
  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  // run limit
  initial begin
    #TIMEOUT_NS;
    $display("simulation failed");
    $finish;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // queue one frame built against the current register settings
  function automatic void build_frame(bit bad_marker, len_kind_t len_kind, bit bad_crc,
                                      fill_kind_t fill);
    logic [7:0] f[FRAME_LEN];
    logic [7:0] c;
    logic [7:0] lim;
    lim = sb.payload_limit;
    for (int i = 0; i < FRAME_LEN; i++) begin
      case (fill)
        FILL_ZERO: f[i] = 8'h00;
        FILL_ONES: f[i] = 8'hFF;
        default:   f[i] = 8'($urandom_range(255));
      endcase
    end
    f[0] = bad_marker ? sb.start_marker ^ 8'($urandom_range(255, 1)) : sb.start_marker;
    if (len_kind == LEN_OVER && lim != 8'hFF) begin
      f[LEN_POS] = $urandom_range(1) ? 8'(lim + 1) : 8'($urandom_range(255, lim + 1));
    end else if (len_kind == LEN_EDGE) begin
      f[LEN_POS] = lim;
    end else begin
      f[LEN_POS] = 8'($urandom_range(lim));
    end
    c = CRC8_SEED;
    for (int i = 0; i < FRAME_LEN - 1; i++) c = crc8_next(c, f[i]);
    f[FRAME_LEN-1] = bad_crc ? c ^ 8'($urandom_range(255, 1)) : c;
    for (int i = 0; i < FRAME_LEN; i++) frame_bytes.push_back(f[i]);
  endfunction

  // mostly well-formed frames, some with one or more defects, a few pure noise
  function automatic void random_frame();
    len_kind_t  lk;
    fill_kind_t fk;
    int         roll;
    if ($urandom_range(99) < 6) begin
      for (int i = 0; i < FRAME_LEN; i++) frame_bytes.push_back(8'($urandom_range(255)));
    end else begin
      roll = $urandom_range(99);
      lk   = (roll < 15) ? LEN_OVER : (roll < 35) ? LEN_EDGE : LEN_FIT;
      roll = $urandom_range(99);
      fk   = (roll < 3) ? FILL_ZERO : (roll < 6) ? FILL_ONES : FILL_RANDOM;
      build_frame($urandom_range(99) < 15, lk, $urandom_range(99) < 15, fk);
    end
  endfunction

  function automatic logic [7:0] next_byte();
    if (frame_bytes.size() == 0) random_frame();
    return frame_bytes.pop_front();
  endfunction

  // one input transaction, with random idle cycles ahead of it
  task automatic send_byte(logic [7:0] b);
    while (take_break()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.take_byte(b);
    sent++;
  endtask

  task automatic run_phase(int n);
    repeat (n) send_byte(next_byte());
    in_ch.valid <= 1'b0;
  endtask

  // wait until every due status is back and the pipeline has emptied
  task automatic settle();
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic cfg_write_unknown();
    cfg_write(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, CFG_PAYLOAD_LIMIT + 1)),
              8'($urandom_range(255)));
  endtask

  // status receiver with random back-pressure and one long hold
  initial begin
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.check_status(out_ch.status, out_ch.computed_crc);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !take_break();
      end
    end
  end

  // stimulus
  initial begin
    int         phase;
    int         n;
    int         roll;
    logic [7:0] lim;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_START_MARKER;
    cfg_ch.data     = 8'h00;
    calm            = 1'b0;
    hold_request    = 1'b0;
    sent            = 0;
    sb              = new();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames under the reset settings: clean frame of all-ones filler at the
    // length limit, every defect at once, length and crc bad, crc bad alone, marker bad alone
    build_frame(1'b0, LEN_EDGE, 1'b0, FILL_ONES);
    build_frame(1'b1, LEN_OVER, 1'b1, FILL_ZERO);
    build_frame(1'b0, LEN_OVER, 1'b1, FILL_RANDOM);
    build_frame(1'b0, LEN_FIT, 1'b1, FILL_RANDOM);
    build_frame(1'b1, LEN_FIT, 1'b0, FILL_RANDOM);
    run_phase(frame_bytes.size() + $urandom_range(20, 5));

    // random phases; settings change between phases, often in the middle of a frame
    phase = 1;
    while (sent < BYTE_TARGET) begin
      settle();
      n = $urandom_range(290, 200);
      case (phase)
        1: begin
          cfg_write(CFG_START_MARKER, 8'hFF);
          cfg_write(CFG_PAYLOAD_LIMIT, 8'h00);
          calm = 1'b1;
        end
        2: begin
          cfg_write_unknown();
          cfg_write(CFG_START_MARKER, 8'h00);
          cfg_write(CFG_PAYLOAD_LIMIT, 8'hFF);
          calm = 1'b0;
        end
        3: begin
          cfg_write(CFG_START_MARKER, 8'($urandom_range(255)));
          cfg_write(CFG_PAYLOAD_LIMIT, 8'($urandom_range(255)));
          calm         = 1'b1;
          hold_request = 1'b1;
          n            = 600;
        end
        default: begin
          roll = $urandom_range(99);
          lim  = (roll < 15) ? 8'h00 : (roll < 30) ? 8'hFF : 8'($urandom_range(255));
          if ($urandom_range(99) < 30) cfg_write_unknown();
          cfg_write(CFG_START_MARKER, 8'($urandom_range(255)));
          cfg_write(CFG_PAYLOAD_LIMIT, lim);
          calm = 1'b0;
        end
      endcase
      // stop close to the byte target
      if (n > BYTE_TARGET - sent) n = BYTE_TARGET - sent;
      run_phase(n);
      phase++;
    end
    calm = 1'b0;

    // drain and finish
    for (int w = 0; w < 5000 && sb.pending() > 0; w++) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() > 0) sb.report($sformatf("%0d frame statuses never came", sb.pending()));
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
